/* hdl/ssm_pkg.sv */
`timescale 1ns / 1ps
// ssm_pkg: shared types, constants and helpers for the signature superset match block.
// No dependencies.
package ssm_pkg;

    localparam int MAX_TARGETS = 64;
    localparam int SIG_BYTES   = 8;
    localparam int RESULT_CAP  = 64;

    localparam int SIG_W   = 64;
    localparam int QNUM_W  = 16;
    localparam int TIDX_W  = 6;
    localparam int IDX_W   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CNT_W   = $clog2(MAX_TARGETS + 1);
    localparam int NM_W    = $clog2(RESULT_CAP + 1);
    localparam int FQ_DEPTH = 4;
    localparam int FQ_PW    = $clog2(FQ_DEPTH);

    localparam logic [SIG_W-1:0] SIG_MASK = {SIG_W{1'b1}} >> (SIG_W - 8 * SIG_BYTES);

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_QUERY = 2'd1,
        FN_CLEAR = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_MATCH   = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_LOADED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_bk_state;

    typedef struct packed {
        t_func            func;
        logic [SIG_W-1:0] sig;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [QNUM_W-1:0] qnum;
        logic [TIDX_W-1:0] tidx;
        logic              eq;
        logic              last;
    } t_result;

    function automatic logic [TIDX_W-1:0] to_tidx(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            return w[TIDX_W-1:0];
        end
    endfunction

endpackage

/* hdl/signature_superset_match_top.sv */
`timescale 1ns / 1ps
// signature_superset_match_top: top level; front queue, execution side and
// output packing. Depends on ssm_pkg, ssm_front, ssm_back.
//
// Input stream (s side): tuser = function (0 load, 1 query, 2 clear, 3 ignored),
// tdata = 64-bit signature. Output stream (m side): tuser = status, tdata =
// query number, target index, equal flag; tlast marks the final result of an item.
// Commands pass through a 4-entry queue, so input is taken while the
// execution side is busy or the output is stalled.
// Load and clear: one result each, written to the output register when the command leaves the queue.
// Query: the target memory has one read port and is scanned one entry per
// cycle unless a match is held up by a stalled output; a query emits one match
// result per matching target (in index order), or a single no-match result.
// Results are held in an output register; a stalled receiver freezes the scan
// and, once the queue fills, input tready drops. No result is lost.
// Reset clears the target count, the query number, the queue and the output
// register; the target memory is not cleared and needs no clearing pass.
module signature_superset_match_top
    import ssm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [SIG_W-1:0]  i_s_tdata,   // signature[63:0]
    input  logic [1:0]        i_s_tuser,   // func[1:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [23:0]       o_m_tdata,   // query_number[15:0], target_index[21:16],
                                           // is_equal[22], zero[23]
    output logic [2:0]        o_m_tuser,   // status[2:0]
    output logic              o_m_tlast    // last
);

    logic    cmd_vld;
    t_cmd    cmd;
    logic    cmd_pop;
    t_result res;

    ssm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_cmd_vld  (cmd_vld),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    ssm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (cmd),
        .o_cmd_pop (cmd_pop),
        .o_res_vld (o_m_tvalid),
        .o_res     (res),
        .i_res_rdy (i_m_tready)
    );

    assign o_m_tdata = {1'b0, res.eq, res.tidx, res.qnum};
    assign o_m_tuser = res.status;
    assign o_m_tlast = res.last;

`ifndef SYNTH
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_MATCH) |-> o_m_tlast)
        else $error("non-match result without last");

    a_eq_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[22] |-> (o_m_tuser == ST_MATCH))
        else $error("equal flag on non-match result");

    a_clr_qnum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_CLEARED) |-> (o_m_tdata[15:0] == '0))
        else $error("cleared result with nonzero query number");
`endif

endmodule

/* hdl/ssm_front.sv */
`timescale 1ns / 1ps
// ssm_front: input side; accepts transfers, drops unused function codes and
// queues commands for the execution side. Depends on ssm_pkg.
module ssm_front
    import ssm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [SIG_W-1:0]  i_s_tdata,
    input  logic [1:0]        i_s_tuser,
    output logic              o_cmd_vld,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    t_cmd              r_q [FQ_DEPTH];
    logic [FQ_PW-1:0]  r_wp, n_wp;
    logic [FQ_PW-1:0]  r_rp, n_rp;
    logic [FQ_PW:0]    r_cnt, n_cnt;
    logic              acc;
    logic              push;
    logic              pop;
    t_func             func;

    assign func       = t_func'(i_s_tuser);
    assign o_s_tready = (r_cnt != (FQ_PW+1)'(FQ_DEPTH));
    assign acc        = i_s_tvalid && o_s_tready;
    assign push       = acc && (func inside {FN_LOAD, FN_QUERY, FN_CLEAR});
    assign o_cmd_vld  = (r_cnt != '0);
    assign pop        = i_cmd_pop && o_cmd_vld;
    assign o_cmd      = r_q[r_rp];

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (FQ_PW+1)'(push) - (FQ_PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{func: func, sig: i_s_tdata};
        end
    end

endmodule

/* hdl/ssm_back.sv */
`timescale 1ns / 1ps
// ssm_back: execution side; target memory, load/clear handling, query scan
// and the output register. Depends on ssm_pkg.
module ssm_back
    import ssm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_vld,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_res_vld,
    output t_result o_res,
    input  logic    i_res_rdy
);

    logic [SIG_W-1:0]  r_mem [MAX_TARGETS];
    logic [SIG_W-1:0]  r_rd_data;

    t_bk_state         r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [QNUM_W-1:0] r_qcnt, n_qcnt;
    logic              r_out_vld, n_out_vld;
    t_result           r_out, n_out;
    logic              r_rd_vld, n_rd_vld;
    logic              r_pend_vld, n_pend_vld;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]  r_pend_idx, n_pend_idx;
    logic              r_pend_eq, n_pend_eq;
    logic [NM_W-1:0]   r_nmatch, n_nmatch;
    logic [SIG_W-1:0]  r_src, n_src;
    logic [QNUM_W-1:0] r_qnum, n_qnum;

    logic out_free;
    logic pop;
    logic cap_hit;
    logic scan_end;
    logic hit;
    logic hit_eq;
    logic stall;
    logic issue;
    logic finish;
    logic wr_en;

    assign out_free = !r_out_vld || i_res_rdy;
    assign pop      = (r_state == BK_IDLE) && i_cmd_vld && out_free;
    assign cap_hit  = (r_nmatch == NM_W'(RESULT_CAP));
    assign scan_end = (r_addr == r_count) || cap_hit;
    assign hit      = r_rd_vld && ((r_src & ~r_rd_data) == '0) && !cap_hit;
    assign hit_eq   = (r_src == (r_rd_data & SIG_MASK));
    assign stall    = hit && r_pend_vld && !out_free;
    assign issue    = (r_state == BK_SCAN) && !stall && !scan_end;
    assign finish   = (r_state == BK_SCAN) && scan_end && !r_rd_vld && out_free;
    assign wr_en    = pop && (i_cmd.func == FN_LOAD) && (r_count != CNT_W'(MAX_TARGETS));

    assign o_cmd_pop = pop;
    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (pop && (i_cmd.func == FN_QUERY)) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (finish) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_qcnt     = r_qcnt;
        n_out_vld  = r_out_vld && !i_res_rdy;
        n_out      = r_out;
        n_rd_vld   = r_rd_vld;
        n_pend_vld = r_pend_vld;
        n_addr     = r_addr;
        n_rd_idx   = r_rd_idx;
        n_pend_idx = r_pend_idx;
        n_pend_eq  = r_pend_eq;
        n_nmatch   = r_nmatch;
        n_src      = r_src;
        n_qnum     = r_qnum;
        case (r_state)
            BK_IDLE: begin
                if (pop) begin
                    case (i_cmd.func)
                        FN_LOAD: begin
                            n_out_vld = 1'b1;
                            if (wr_en) begin
                                n_count = r_count + 1'b1;
                                n_out   = '{status: ST_LOADED, qnum: r_qcnt,
                                            tidx: to_tidx(r_count), eq: 1'b0, last: 1'b1};
                            end else begin
                                n_out   = '{status: ST_FULL, qnum: r_qcnt,
                                            tidx: '0, eq: 1'b0, last: 1'b1};
                            end
                        end
                        FN_QUERY: begin
                            n_src      = i_cmd.sig & SIG_MASK;
                            n_qnum     = r_qcnt;
                            n_qcnt     = r_qcnt + 1'b1;
                            n_addr     = '0;
                            n_nmatch   = '0;
                            n_pend_vld = 1'b0;
                            n_rd_vld   = 1'b0;
                        end
                        FN_CLEAR: begin
                            n_count   = '0;
                            n_qcnt    = '0;
                            n_out_vld = 1'b1;
                            n_out     = '{status: ST_CLEARED, qnum: '0,
                                          tidx: '0, eq: 1'b0, last: 1'b1};
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN: begin
                if (!stall) begin
                    n_rd_vld = issue;
                    if (issue) begin
                        n_rd_idx = r_addr;
                        n_addr   = r_addr + 1'b1;
                    end
                    if (hit) begin
                        if (r_pend_vld) begin
                            n_out_vld = 1'b1;
                            n_out     = '{status: ST_MATCH, qnum: r_qnum,
                                          tidx: to_tidx(r_pend_idx), eq: r_pend_eq,
                                          last: 1'b0};
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_rd_idx;
                        n_pend_eq  = hit_eq;
                        n_nmatch   = r_nmatch + 1'b1;
                    end
                end
                if (finish) begin
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    if (r_pend_vld) begin
                        n_out = '{status: ST_MATCH, qnum: r_qnum,
                                  tidx: to_tidx(r_pend_idx), eq: r_pend_eq, last: 1'b1};
                    end else begin
                        n_out = '{status: ST_NOMATCH, qnum: r_qnum,
                                  tidx: '0, eq: 1'b0, last: 1'b1};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_count    <= '0;
            r_qcnt     <= '0;
            r_out_vld  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_qcnt     <= n_qcnt;
            r_out_vld  <= n_out_vld;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_pend_eq  <= n_pend_eq;
        r_nmatch   <= n_nmatch;
        r_src      <= n_src;
        r_qnum     <= n_qnum;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= i_cmd.sig;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

endmodule

/* tb/tb_signature_superset_match_top.sv */
`timescale 1ns / 1ps
// tb_signature_superset_match_top: self-checking bench for the signature superset match
// block; predicts every result from its own target table. Depends on ssm_pkg and the RTL.
module tb_signature_superset_match_top;
    import ssm_pkg::*;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    // keeps a copy of the target table and the expected result transfers
    class superset_scoreboard;
        logic [SIG_W-1:0]  targets [MAX_TARGETS];
        int unsigned       target_cnt;
        logic [QNUM_W-1:0] query_ctr;
        t_result           expected_results [$];
        int unsigned       errors;

        function new();
            target_cnt = 0;
            query_ctr  = '0;
            errors     = 0;
        endfunction

        function void add_expected(t_result r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void predict_command(logic [1:0] func, logic [SIG_W-1:0] sig);
            t_result          res;
            t_result          prev;
            logic [SIG_W-1:0] src;
            logic [SIG_W-1:0] tgt;
            logic [QNUM_W-1:0] qnum;
            int unsigned      hits;
            res = '0;
            case (func)
                FN_LOAD: begin
                    res.qnum = query_ctr;
                    res.last = 1'b1;
                    if (target_cnt < MAX_TARGETS) begin
                        targets[target_cnt] = sig;
                        res.status = ST_LOADED;
                        res.tidx   = target_cnt[TIDX_W-1:0];
                        target_cnt++;
                    end else begin
                        res.status = ST_FULL;
                    end
                    add_expected(res);
                end
                FN_QUERY: begin
                    src  = sig & SIG_MASK;
                    qnum = query_ctr;
                    query_ctr = query_ctr + 1'b1;
                    hits = 0;
                    prev = '0;
                    for (int j = 0; j < target_cnt; j++) begin
                        tgt = targets[j] & SIG_MASK;
                        if ((src & ~tgt) == '0) begin
                            if (hits >= RESULT_CAP) break;
                            if (hits != 0) add_expected(prev);
                            prev        = '0;
                            prev.status = ST_MATCH;
                            prev.qnum   = qnum;
                            prev.tidx   = j[TIDX_W-1:0];
                            prev.eq     = (src == tgt);
                            hits++;
                        end
                    end
                    if (hits == 0) begin
                        res.status = ST_NOMATCH;
                        res.qnum   = qnum;
                        res.last   = 1'b1;
                        add_expected(res);
                    end else begin
                        prev.last = 1'b1;
                        add_expected(prev);
                    end
                end
                FN_CLEAR: begin
                    target_cnt = 0;
                    query_ctr  = '0;
                    res.status = ST_CLEARED;
                    res.last   = 1'b1;
                    add_expected(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_status status, logic [23:0] data, logic lst);
            t_result got;
            t_result want;
            got.status = status;
            got.qnum   = data[15:0];
            got.tidx   = data[21:16];
            got.eq     = data[22];
            got.last   = lst;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result status=%0d qnum=%0d idx=%0d eq=%0d last=%0d",
                             $realtime, got.status, got.qnum, got.tidx, got.eq, got.last);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.qnum !== want.qnum ||
                got.tidx !== want.tidx || got.eq !== want.eq || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: result differs: exp status=%0d qnum=%0d idx=%0d ",
                              "eq=%0d last=%0d, got status=%0d qnum=%0d idx=%0d ",
                              "eq=%0d last=%0d"},
                             $realtime, want.status, want.qnum, want.tidx, want.eq,
                             want.last, got.status, got.qnum, got.tidx, got.eq, got.last);
            end
        endfunction

        function void check_leftovers();
            if (expected_results.size() != 0) begin
                errors++;
                $display("%0t: %0d expected results never arrived",
                         $realtime, expected_results.size());
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [SIG_W-1:0]  i_s_tdata;   // signature[63:0]
    logic [1:0]        i_s_tuser;   // func[1:0]
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [23:0]       o_m_tdata;   // query_number[15:0], target_index[21:16], is_equal[22]
    logic [2:0]        o_m_tuser;   // status[2:0]
    logic              o_m_tlast;

    superset_scoreboard sb;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    int unsigned        hold_request;

    signature_superset_match_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.predict_command(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(t_status'(o_m_tuser), o_m_tdata, o_m_tlast);
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        int unsigned hold_left;
        hold_left  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_cmd(input logic [1:0] func, input logic [SIG_W-1:0] sig);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = func;
        i_s_tdata  = sig;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [SIG_W-1:0] dense_target();
        logic [SIG_W-1:0] sig;
        int unsigned      nbytes;
        sig = {$urandom, $urandom} | {$urandom, $urandom};
        if ($urandom_range(3) == 0) begin
            nbytes = $urandom_range(1, 8);
            sig = sig & ({SIG_W{1'b1}} >> (8 * (8 - nbytes)));
        end
        return sig;
    endfunction

    task automatic send_random_item();
        int unsigned      pick;
        int unsigned      kind;
        logic [SIG_W-1:0] tgt;
        pick = $urandom_range(99);
        kind = $urandom_range(99);
        if ((sb.target_cnt >= 24 && pick < 15) || pick < 4) begin
            send_cmd(FN_CLEAR, {$urandom, $urandom});
        end else if (pick < 8) begin
            send_cmd(FN_UNUSED, {$urandom, $urandom});
        end else if (pick < 40) begin
            send_cmd(FN_LOAD, dense_target());
        end else if (sb.target_cnt == 0 || kind < 8) begin
            send_cmd(FN_QUERY, {$urandom, $urandom});
        end else if (kind < 15) begin
            send_cmd(FN_QUERY, '0);
        end else begin
            tgt = sb.targets[$urandom_range(sb.target_cnt - 1)];
            if (kind < 40)
                send_cmd(FN_QUERY, tgt);
            else if (kind < 70)
                send_cmd(FN_QUERY, tgt & {$urandom, $urandom});
            else
                send_cmd(FN_QUERY, tgt & {$urandom, $urandom} & {$urandom, $urandom});
        end
    endtask

    task automatic wait_drained(input int unsigned extra);
        int unsigned guard;
        guard = 0;
        while (sb.expected_results.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (extra) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, extremes, equal and strict matches, ignored code
        send_cmd(FN_QUERY, 64'h0);
        send_cmd(FN_LOAD, 64'h0);
        send_cmd(FN_LOAD, {SIG_W{1'b1}});
        send_cmd(FN_LOAD, 64'hA5A5_A5A5_A5A5_A5A5);
        send_cmd(FN_LOAD, 64'h0000_0000_00FF_00FF);
        send_cmd(FN_UNUSED, {SIG_W{1'b1}});
        send_cmd(FN_QUERY, 64'h0);
        send_cmd(FN_QUERY, {SIG_W{1'b1}});
        send_cmd(FN_QUERY, 64'h5A5A_5A5A_5A5A_5A5A);
        send_cmd(FN_QUERY, 64'hA5A5_A5A5_A5A5_A5A5);
        send_cmd(FN_QUERY, 64'h0000_0000_0005_0081);
        send_cmd(FN_QUERY, 64'h8000_0000_0000_0000);
        send_cmd(FN_CLEAR, 64'h0);
        send_cmd(FN_QUERY, 64'h0);
        send_cmd(FN_LOAD, 64'h0123_4567_89AB_CDEF);
        send_cmd(FN_QUERY, 64'h0123_4567_89AB_CDEF);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 0) begin
                // full table, then loads beyond it
                send_cmd(FN_CLEAR, 64'h0);
                for (int k = 0; k < MAX_TARGETS + 2; k++) send_cmd(FN_LOAD, dense_target());
                send_cmd(FN_QUERY, 64'h0);
                send_cmd(FN_QUERY, sb.targets[MAX_TARGETS - 1] & 64'hF0F0_F0F0_F0F0_F0F0);
                send_cmd(FN_CLEAR, 64'h0);
            end
            if (ph == 3) begin
                // long receiver hold-off while many-match queries keep coming
                send_cmd(FN_CLEAR, 64'h0);
                for (int k = 0; k < 12; k++) send_cmd(FN_LOAD, dense_target());
                hold_request = 400;
                for (int k = 0; k < 6; k++) send_cmd(FN_QUERY, 64'h0);
                send_cmd(FN_CLEAR, 64'h0);
            end
            repeat (11) send_random_item();
        end

        i_s_tvalid = 1'b0;
        wait_drained(400);
        sb.check_leftovers();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
